// ===== rtl/i2cm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

  localparam int unsigned CFG_WIDTH = 16;
  localparam logic [CFG_WIDTH-1:0] PHASE_DELAY_RESET = 16'd5;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  localparam logic [2:0] CMD_IDLE = 3'd0;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_in;
  } item_t;

endpackage

`default_nettype wire

// ===== rtl/i2cm_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2cm_in_stage
  import i2cm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] operation,
  input  wire logic [7:0] write_data,
  input  wire logic       send_ack,
  input  wire logic       sda_in,
  input  wire logic       adv,
  output logic            item_valid,
  output item_t           item
);

  assign in_stall = item_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item.operation  <= operation;
      item.write_data <= write_data;
      item.send_ack   <= send_ack;
      item.sda_in     <= sda_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/i2cm_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2cm_core
  import i2cm_pkg::*;
#(
  parameter int unsigned DELAY_WIDTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_WIDTH-1:0] cfg_wr_data,
  input  wire logic                 item_valid,
  input  wire item_t                item,
  output logic                      adv,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      scl_out,
  output logic                      sda_out,
  output logic                      busy_res,
  output logic                      done_res,
  output logic [7:0]                read_data,
  output logic                      ack_level,
  output logic                      command_rejected
);

  localparam logic [32:0] DELAY_MAX = (33'd1 << DELAY_WIDTH) - 33'd1;

  logic [CFG_WIDTH-1:0]   phase_delay;
  logic                   scl_level, scl_level_next;
  logic                   sda_level, sda_level_next;
  logic [2:0]             active_command, active_command_next;
  logic [1:0]             phase_step, phase_step_next;
  logic [3:0]             bit_counter, bit_counter_next;
  logic [DELAY_WIDTH-1:0] delay_count, delay_count_next;
  logic [7:0]             shift_byte, shift_byte_next;
  logic                   ack_choice, ack_choice_next;
  logic                   last_ack, last_ack_next;
  logic [7:0]             read_hold, read_hold_next;
  logic                   done_next, rejected_next;
  logic [DELAY_WIDTH-1:0] delay_load;
  logic                   busy;
  logic                   fin;

  assign adv  = !out_valid || !out_stall;
  assign busy = active_command != CMD_IDLE;

  // saturate to the counter width, zero acts as one
  always_comb begin
    if ({17'd0, phase_delay} > DELAY_MAX) begin
      delay_load = '1;
    end else begin
      delay_load = DELAY_WIDTH'(phase_delay);
    end
    if (delay_load == '0) begin
      delay_load = DELAY_WIDTH'(1);
    end
  end

  always_comb begin
    scl_level_next      = scl_level;
    sda_level_next      = sda_level;
    active_command_next = active_command;
    phase_step_next     = phase_step;
    bit_counter_next    = bit_counter;
    delay_count_next    = delay_count;
    shift_byte_next     = shift_byte;
    ack_choice_next     = ack_choice;
    last_ack_next       = last_ack;
    read_hold_next      = read_hold;
    done_next           = 1'b0;
    rejected_next       = 1'b0;
    fin                 = 1'b0;
    if (item_valid) begin
      if (item.operation == OP_TICK) begin
        if (busy) begin
          if (delay_count > DELAY_WIDTH'(1)) begin
            delay_count_next = delay_count - DELAY_WIDTH'(1);
          end else begin
            case (active_command)
              OP_START: begin
                if (phase_step == 2'd3) begin
                  fin = 1'b1;
                end else begin
                  phase_step_next = phase_step + 2'd1;
                  case (phase_step)
                    2'd0:    scl_level_next = 1'b1;
                    2'd1:    sda_level_next = 1'b0;
                    default: scl_level_next = 1'b0;
                  endcase
                end
              end
              OP_STOP: begin
                if (phase_step >= 2'd2) begin
                  fin = 1'b1;
                end else begin
                  phase_step_next = phase_step + 2'd1;
                  if (phase_step == 2'd0) begin
                    scl_level_next = 1'b1;
                  end else begin
                    sda_level_next = 1'b1;
                  end
                end
              end
              OP_WRITE: begin
                if (!bit_counter[3]) begin
                  if (phase_step < 2'd2) begin
                    phase_step_next = phase_step + 2'd1;
                    scl_level_next  = (phase_step == 2'd0);
                  end else begin
                    bit_counter_next = bit_counter + 4'd1;
                    phase_step_next  = 2'd0;
                    if (!bit_counter_next[3]) begin
                      sda_level_next = shift_byte[~bit_counter_next[2:0]];
                    end else begin
                      sda_level_next = 1'b1;
                    end
                  end
                end else if (phase_step == 2'd0) begin
                  phase_step_next = 2'd1;
                  scl_level_next  = 1'b1;
                end else if (phase_step == 2'd1) begin
                  phase_step_next = 2'd2;
                  last_ack_next   = item.sda_in;
                  scl_level_next  = 1'b0;
                end else begin
                  fin = 1'b1;
                end
              end
              OP_READ: begin
                if (!bit_counter[3]) begin
                  if (phase_step == 2'd0) begin
                    scl_level_next  = 1'b1;
                    phase_step_next = 2'd1;
                  end else begin
                    shift_byte_next[~bit_counter[2:0]] =
                      shift_byte[~bit_counter[2:0]] | item.sda_in;
                    scl_level_next = 1'b0;
                    if (bit_counter == 4'd7) begin
                      sda_level_next = !ack_choice;
                    end
                    bit_counter_next = bit_counter + 4'd1;
                    phase_step_next  = 2'd0;
                  end
                end else if (phase_step == 2'd0) begin
                  scl_level_next  = 1'b1;
                  phase_step_next = 2'd1;
                end else if (phase_step == 2'd1) begin
                  scl_level_next  = 1'b0;
                  phase_step_next = 2'd2;
                end else begin
                  sda_level_next = 1'b1;
                  read_hold_next = shift_byte;
                  fin            = 1'b1;
                end
              end
              default: begin
                fin = 1'b1;
              end
            endcase
            if (fin) begin
              active_command_next = CMD_IDLE;
              phase_step_next     = 2'd0;
              bit_counter_next    = 4'd0;
              delay_count_next    = '0;
              done_next           = 1'b1;
            end else begin
              delay_count_next = delay_load;
            end
          end
        end
      end else if (item.operation <= OP_READ) begin
        if (busy) begin
          rejected_next = 1'b1;
        end else begin
          active_command_next = item.operation;
          phase_step_next     = 2'd0;
          bit_counter_next    = 4'd0;
          delay_count_next    = delay_load;
          case (item.operation)
            OP_START: sda_level_next = 1'b1;
            OP_STOP:  sda_level_next = 1'b0;
            OP_WRITE: begin
              shift_byte_next = item.write_data;
              sda_level_next  = item.write_data[7];
            end
            default: begin
              shift_byte_next = 8'd0;
              ack_choice_next = item.send_ack;
              sda_level_next  = 1'b1;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_delay      <= PHASE_DELAY_RESET;
      out_valid        <= 1'b0;
      scl_level        <= 1'b1;
      sda_level        <= 1'b1;
      active_command   <= CMD_IDLE;
      phase_step       <= 2'd0;
      bit_counter      <= 4'd0;
      delay_count      <= '0;
      shift_byte       <= 8'd0;
      ack_choice       <= 1'b0;
      last_ack         <= 1'b0;
      read_hold        <= 8'd0;
      done_res         <= 1'b0;
      command_rejected <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        phase_delay <= cfg_wr_data;
      end
      if (adv) begin
        out_valid        <= item_valid;
        scl_level        <= scl_level_next;
        sda_level        <= sda_level_next;
        active_command   <= active_command_next;
        phase_step       <= phase_step_next;
        bit_counter      <= bit_counter_next;
        delay_count      <= delay_count_next;
        shift_byte       <= shift_byte_next;
        ack_choice       <= ack_choice_next;
        last_ack         <= last_ack_next;
        read_hold        <= read_hold_next;
        done_res         <= done_next;
        command_rejected <= rejected_next;
      end
    end
  end

  assign scl_out   = scl_level;
  assign sda_out   = sda_level;
  assign busy_res  = busy;
  assign read_data = read_hold;
  assign ack_level = last_ack;

endmodule

`default_nettype wire

// ===== rtl/i2c_master_byte_engine_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// result word registered by the core from the word held in the input register
// throughput: 1 word per cycle while not stalled, one result word per input word
// one input register feeds the combinational phase sequencer and result register
// reset (sync, active high): scl and sda released high, engine idle, no result valid
// phase_delay resets to 5 ticks

module i2c_master_byte_engine_unit
  import i2cm_pkg::*;
#(
  parameter int unsigned DELAY_WIDTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_WIDTH-1:0] cfg_wr_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [2:0]           operation,
  input  wire logic [7:0]           write_data,
  input  wire logic                 send_ack,
  input  wire logic                 sda_in,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      scl_out,
  output logic                      sda_out,
  output logic                      busy_res,
  output logic                      done_res,
  output logic [7:0]                read_data,
  output logic                      ack_level,
  output logic                      command_rejected
);

  logic  adv;
  logic  item_valid;
  item_t item;

  i2cm_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .write_data (write_data),
    .send_ack   (send_ack),
    .sda_in     (sda_in),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  i2cm_core #(
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_core (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .item_valid       (item_valid),
    .item             (item),
    .adv              (adv),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .scl_out          (scl_out),
    .sda_out          (sda_out),
    .busy_res         (busy_res),
    .done_res         (done_res),
    .read_data        (read_data),
    .ack_level        (ack_level),
    .command_rejected (command_rejected)
  );

endmodule

`default_nettype wire

// ===== rtl/i2cm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2cm_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       scl_out,
  input wire logic       sda_out,
  input wire logic       busy_res,
  input wire logic       done_res,
  input wire logic [7:0] read_data,
  input wire logic       ack_level,
  input wire logic       command_rejected
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(scl_out) && $stable(sda_out)
      && $stable(busy_res) && $stable(done_res) && $stable(read_data)
      && $stable(ack_level) && $stable(command_rejected))
    else $error("result word changed while stalled");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res && !command_rejected)
    else $error("done while still busy or rejecting");

  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && command_rejected |-> busy_res)
    else $error("command rejected while idle");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind i2c_master_byte_engine_unit i2cm_checker u_chk (.*);

`default_nettype wire
